### rtl/gmd_pkg.sv
// ----------------------------------------------------------------------------
// gmd_pkg: shared definitions for the grid motion detector
// Field widths, segment grid size, result kinds and register indexes.
// ----------------------------------------------------------------------------
package gmd_pkg;

  // Segment grid: eight columns by four rows of segments.
  localparam int SEG_X = 8;
  localparam int SEG_Y = 4;
  localparam int SEG_XW = 3;
  localparam int SEG_YW = 2;

  // Field widths.
  localparam int LUMA_W = 8;
  localparam int SEG_W = 5;
  localparam int CNT_W = 6;
  localparam int MASK_W = 32;
  localparam int MAX_FOUND = 32;

  // Output tdata layout, lowest bit first.
  localparam int OUT_SEG_LSB = 0;
  localparam int OUT_CNT_LSB = OUT_SEG_LSB + SEG_W;
  localparam int OUT_MASK_LSB = OUT_CNT_LSB + CNT_W;
  localparam int OUT_USED_W = OUT_MASK_LSB + MASK_W;
  localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int IN_DATA_W = LUMA_W;

  // Configuration port.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIFF_THRESHOLD = 2'd0,
    REG_MAX_SEGMENTS   = 2'd1,
    REG_GRID_COLS      = 2'd2,
    REG_GRID_ROWS      = 2'd3
  } cfg_reg_t;

  // Register reset values.
  localparam logic [7:0] RST_DIFF_THRESHOLD = 8'd16;
  localparam logic [5:0] RST_MAX_SEGMENTS = 6'd32;
  localparam logic [6:0] RST_GRID_COLS = 7'd64;
  localparam logic [5:0] RST_GRID_ROWS = 6'd48;

  // Result kinds carried on tuser.
  localparam logic KIND_SEGMENT = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

endpackage

### rtl/grid_motion_detector.sv
// ----------------------------------------------------------------------------
// grid_motion_detector: frame difference motion detection on an 8x4 grid
// Compares each pixel with a stored reference frame and reports newly
// flagged segments plus an end of frame summary.
// ----------------------------------------------------------------------------
// Usage notes.
// The input stream carries one luma sample per beat in raster order; in_tuser
// marks the first pixel of a frame. The first complete frame after reset is
// written to the reference memory and produces no results. Every pixel of a
// later frame is compared with its reference pixel until the segment limit
// is reached; the first pixel over the threshold in a segment yields a
// segment beat, and the last pixel of a frame yields a summary beat
// (out_tuser high) with the count and segment mask. The idle state takes a
// pixel and reads the reference memory, whose read data is registered; the
// look state compares it, updates the frame state and loads any result into
// the output register; ST_SECOND loads a summary that follows a segment beat.
// While the receiver stalls, a finished result waits in the output register
// and the next pixel is still taken and read; the compare stage waits only
// when it has a result to hand over and the register is still full.
// Reset clears all control state and restores the register defaults; the
// reference memory is not cleared, since the first frame overwrites it.
// ----------------------------------------------------------------------------
module grid_motion_detector
  import gmd_pkg::*;
#(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // Pixel input: tdata = {luma}, tuser = {frame_start}.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  // Results: tdata = {zero fill, seg_mask, seg_count, segment}, tuser = {kind}.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser,
  output logic                  out_tlast
);

  localparam int CPW = $clog2(MAX_COLS);
  localparam int RPW = $clog2(MAX_ROWS);
  localparam int CNW = $clog2(MAX_COLS + 1);
  localparam int RNW = $clog2(MAX_ROWS + 1);
  localparam int XW = (CNW > 7) ? CNW : 7;
  localparam int YW = (RNW > 6) ? RNW : 6;
  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW = $clog2(DEPTH);
  localparam int SXW = CNW + SEG_XW;
  localparam int SYW = RNW + SEG_YW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SECOND
  } state_t;

  // Configuration registers.
  logic [7:0] thr_r;
  logic [5:0] maxseg_r;
  logic [6:0] gcols_r;
  logic [5:0] grows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= RST_DIFF_THRESHOLD;
      maxseg_r <= RST_MAX_SEGMENTS;
      gcols_r  <= RST_GRID_COLS;
      grows_r  <= RST_GRID_ROWS;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DIFF_THRESHOLD: thr_r    <= cfg_wdata;
        REG_MAX_SEGMENTS:   maxseg_r <= cfg_wdata[5:0];
        REG_GRID_COLS:      gcols_r  <= cfg_wdata[6:0];
        REG_GRID_ROWS:      grows_r  <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  // Frame state and pipeline registers.
  state_t              state_r;
  logic                ref_valid_r;
  logic [CPW-1:0]      col_pos_r;
  logic [RPW-1:0]      row_pos_r;
  logic [MASK_W-1:0]   found_mask_r;
  logic [CNT_W-1:0]    found_count_r;
  logic                stopped_r;
  logic [LUMA_W-1:0]   p_luma_r;
  logic [SEG_W-1:0]    p_seg_r;
  logic                p_cmp_r;
  logic                p_sum_r;
  logic                p_fe_r;
  logic [LUMA_W-1:0]   rd_data_r;
  logic                out_valid_r;
  logic                out_kind_r;
  logic [SEG_W-1:0]    out_seg_r;
  logic [CNT_W-1:0]    out_cnt_r;
  logic [MASK_W-1:0]   out_mask_r;
  logic                out_last_r;
  logic [CNT_W-1:0]    hold_cnt_r;
  logic [MASK_W-1:0]   hold_mask_r;

  // Clamp the geometry and the segment limit to their legal ranges.
  logic [XW-1:0]  gcols_x;
  logic [YW-1:0]  grows_x;
  logic [CNW-1:0] cols_c;
  logic [RNW-1:0] rows_c;
  logic [CNT_W-1:0] maxs_c;

  assign gcols_x = XW'(gcols_r);
  assign grows_x = YW'(grows_r);

  always_comb begin
    if (gcols_x == '0) begin
      cols_c = CNW'(1);
    end else if (gcols_x > XW'(MAX_COLS)) begin
      cols_c = CNW'(MAX_COLS);
    end else begin
      cols_c = CNW'(gcols_x);
    end
    if (grows_x == '0) begin
      rows_c = RNW'(1);
    end else if (grows_x > YW'(MAX_ROWS)) begin
      rows_c = RNW'(MAX_ROWS);
    end else begin
      rows_c = RNW'(grows_x);
    end
    if (maxseg_r == '0) begin
      maxs_c = CNT_W'(1);
    end else if (maxseg_r > CNT_W'(MAX_FOUND)) begin
      maxs_c = CNT_W'(MAX_FOUND);
    end else begin
      maxs_c = maxseg_r;
    end
  end

  // Current position; a frame start forces the origin, and a position past
  // the geometry is held at the last column or row.
  logic [CNW-1:0] col_raw;
  logic [RNW-1:0] row_raw;
  logic [CPW-1:0] col;
  logic [RPW-1:0] row;
  logic           row_end;
  logic           frame_end;
  logic [AW-1:0]  addr;

  assign col_raw = in_tuser ? '0 : CNW'(col_pos_r);
  assign row_raw = in_tuser ? '0 : RNW'(row_pos_r);
  assign col = (col_raw < cols_c) ? CPW'(col_raw) : CPW'(cols_c - CNW'(1));
  assign row = (row_raw < rows_c) ? RPW'(row_raw) : RPW'(rows_c - RNW'(1));
  assign row_end = (CNW'(col) + CNW'(1)) >= cols_c;
  assign frame_end = row_end && ((RNW'(row) + RNW'(1)) >= rows_c);
  assign addr = AW'(row) * AW'(MAX_COLS) + AW'(col);

  // Segment number: count the grid lines that the scaled position has passed.
  logic [SEG_X-2:0] sx_hit;
  logic [SEG_Y-2:0] sy_hit;
  logic [SEG_W-1:0] seg;

  always_comb begin
    for (int k = 1; k < SEG_X; k++) begin
      sx_hit[k-1] = (SXW'(col) << SEG_XW) >= (SXW'(k) * SXW'(cols_c));
    end
    for (int k = 1; k < SEG_Y; k++) begin
      sy_hit[k-1] = (SYW'(row) << SEG_YW) >= (SYW'(k) * SYW'(rows_c));
    end
  end

  assign seg = {SEG_YW'($countones(sy_hit)), SEG_XW'($countones(sx_hit))};

  // Reference frame memory: written during capture, read on every accepted pixel.
  logic [LUMA_W-1:0] ref_mem [DEPTH];
  logic              in_acc;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (!ref_valid_r) begin
        ref_mem[addr] <= in_tdata;
      end
      rd_data_r <= ref_mem[addr];
    end
  end

  // Compare stage.
  logic [LUMA_W-1:0] diff;
  logic              hit;
  logic              out_free;
  logic              advance;
  logic              load_out;
  logic [MASK_W-1:0] mask_nxt;
  logic [CNT_W-1:0]  count_nxt;

  assign diff = (p_luma_r > rd_data_r) ? (p_luma_r - rd_data_r) : (rd_data_r - p_luma_r);
  assign hit = p_cmp_r && !found_mask_r[p_seg_r] && (diff > thr_r);
  assign out_free = !out_valid_r || out_tready;
  assign advance = (!hit && !p_sum_r) || out_free;
  assign mask_nxt = hit ? (found_mask_r | (MASK_W'(1) << p_seg_r)) : found_mask_r;
  assign count_nxt = hit ? (found_count_r + CNT_W'(1)) : found_count_r;

  // A new beat enters the output register in this cycle.
  assign load_out = ((state_r == ST_LOOK) && advance && (hit || p_sum_r)) ||
                    ((state_r == ST_SECOND) && out_free);

  // Sequencer, frame state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      ref_valid_r   <= 1'b0;
      col_pos_r     <= '0;
      row_pos_r     <= '0;
      found_mask_r  <= '0;
      found_count_r <= '0;
      stopped_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && !load_out) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            p_luma_r <= in_tdata;
            p_seg_r  <= seg;
            p_cmp_r  <= ref_valid_r && (in_tuser || !stopped_r);
            p_sum_r  <= ref_valid_r && frame_end;
            p_fe_r   <= frame_end;
            if (in_tuser) begin
              found_mask_r  <= '0;
              found_count_r <= '0;
              stopped_r     <= 1'b0;
            end
            if (frame_end) begin
              ref_valid_r <= 1'b1;
              col_pos_r   <= '0;
              row_pos_r   <= '0;
            end else if (row_end) begin
              col_pos_r <= '0;
              row_pos_r <= row + RPW'(1);
            end else begin
              col_pos_r <= col + CPW'(1);
              row_pos_r <= row;
            end
            state_r <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (advance) begin
            // The frame state restarts after the last pixel of a frame.
            if (p_fe_r) begin
              found_mask_r  <= '0;
              found_count_r <= '0;
              stopped_r     <= 1'b0;
            end else begin
              found_mask_r  <= mask_nxt;
              found_count_r <= count_nxt;
              if (hit && (count_nxt >= maxs_c)) begin
                stopped_r <= 1'b1;
              end
            end
            state_r <= (hit && p_sum_r) ? ST_SECOND : ST_IDLE;
            if (hit) begin
              out_valid_r <= 1'b1;
              out_kind_r  <= KIND_SEGMENT;
              out_seg_r   <= p_seg_r;
              out_cnt_r   <= count_nxt;
              out_mask_r  <= mask_nxt;
              out_last_r  <= !p_sum_r;
              if (p_sum_r) begin
                hold_cnt_r  <= count_nxt;
                hold_mask_r <= mask_nxt;
              end
            end else if (p_sum_r) begin
              out_valid_r <= 1'b1;
              out_kind_r  <= KIND_SUMMARY;
              out_seg_r   <= '0;
              out_cnt_r   <= count_nxt;
              out_mask_r  <= mask_nxt;
              out_last_r  <= 1'b1;
            end
          end
        end
        ST_SECOND: begin
          // Summary that follows a segment beat from the same pixel.
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= KIND_SUMMARY;
            out_seg_r   <= '0;
            out_cnt_r   <= hold_cnt_r;
            out_mask_r  <= hold_mask_r;
            out_last_r  <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Output beat packing.
  assign out_tvalid = out_valid_r;
  assign out_tuser = out_kind_r;
  assign out_tlast = out_last_r;
  assign out_tdata = OUT_DATA_W'({out_mask_r, out_cnt_r, out_seg_r});

endmodule

### rtl/gmd_checker.sv
// ----------------------------------------------------------------------------
// gmd_checker: port level checks for the grid motion detector
// Watches the result channel and checks the consistency of each beat.
// ----------------------------------------------------------------------------
module gmd_checker
  import gmd_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser,
  input logic                  out_tlast
);

  logic [SEG_W-1:0]  seg_f;
  logic [CNT_W-1:0]  cnt_f;
  logic [MASK_W-1:0] mask_f;

  assign seg_f = out_tdata[OUT_SEG_LSB +: SEG_W];
  assign cnt_f = out_tdata[OUT_CNT_LSB +: CNT_W];
  assign mask_f = out_tdata[OUT_MASK_LSB +: MASK_W];

  // A stalled beat stays in place.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // A summary closes the results of its pixel and names no segment.
  a_summary: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_SUMMARY) |-> out_tlast && (seg_f == '0))
    else $error("summary beat malformed");

  // A flagged segment appears in its own mask and the count matches the mask.
  a_seg_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_SEGMENT) |-> mask_f[seg_f]
      && (cnt_f != '0))
    else $error("segment beat not in its mask");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'($countones(mask_f)) == 32'(cnt_f)))
    else $error("segment count disagrees with mask");

endmodule

bind grid_motion_detector gmd_checker u_gmd_checker (.*);
